[rtl/fpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg: shared constants for the fractal Perlin pixel generator
// Pipeline depths, datapath widths, hash multipliers, cosine table, CSR codes.
// ----------------------------------------------------------------------------
package fpp_pkg;

   localparam int OCTAVES     = 9;
   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 16;

   // quotient of coord << (FRAC_BITS + OCTAVES - 1) by the grid size
   localparam int POS_W       = COORD_BITS + FRAC_BITS + OCTAVES - 1;
   // biased contrast value fed to the divide-by-ten
   localparam int CONTRAST_W  = 36;
   localparam int DIV_W       = (POS_W > CONTRAST_W) ? POS_W : CONTRAST_W;
   localparam int DIVISOR_W   = 16;
   localparam int DIV_STEP    = 4;
   localparam int DIV_STAGES  = (DIV_W + DIV_STEP - 1) / DIV_STEP;

   localparam int LANE_STAGES  = 8;
   localparam int TREE_STAGES  = 2;
   // divide by ten: partial products, then sum and shift
   localparam int RECIP_STAGES = 2;
   localparam int PIPE_DEPTH   = DIV_STAGES + LANE_STAGES + TREE_STAGES + 1
                                 + RECIP_STAGES + 1;

   localparam int NOISE_W     = 34;
   localparam int SUM_W       = 36;
   localparam int GROUPS      = (OCTAVES + 3) / 4;

   localparam int GRAY_W      = 9;
   localparam int PIXEL_W     = 17;

   localparam logic [31:0] HASH_M1 = 32'd3284157443;
   localparam logic [31:0] HASH_M2 = 32'd1911520717;
   localparam logic [31:0] HASH_M3 = 32'd2048419325;

   // cos(k*pi/16) in Q1.15 and the drop to the next entry
   localparam logic [15:0] COS_TAB [8] = '{
      16'd32767, 16'd32138, 16'd30273, 16'd27245,
      16'd23170, 16'd18205, 16'd12540, 16'd6393
   };
   localparam logic [15:0] COS_STEP [8] = '{
      16'd629, 16'd1865, 16'd3028, 16'd4075,
      16'd4965, 16'd5665, 16'd6147, 16'd6393
   };

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID = 4'd1;

   localparam logic [DIVISOR_W-1:0] GRID_RESET = 16'd400;

endpackage

[rtl/fpp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_div: pipelined restoring divider
// Unsigned quotient, DIV_STEP quotient bits per register stage.
// ----------------------------------------------------------------------------
module fpp_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [fpp_pkg::DIV_W-1:0]      dividend,
   input  logic [fpp_pkg::DIVISOR_W-1:0]  divisor,
   output logic [fpp_pkg::DIV_W-1:0]      quotient
);
   import fpp_pkg::*;

   logic [DIV_W-1:0]     acc_ff [DIV_STAGES];
   logic [DIV_W-1:0]     acc_in [DIV_STAGES];
   logic [DIVISOR_W-1:0] rem_ff [DIV_STAGES];
   logic [DIVISOR_W-1:0] rem_in [DIV_STAGES];

   // shift dividend bits out the top, quotient bits in at the bottom
   function automatic logic [DIVISOR_W+DIV_W-1:0] div_stage(
      input logic [DIV_W-1:0]     acc,
      input logic [DIVISOR_W-1:0] rem,
      input logic [DIVISOR_W-1:0] d,
      input int                   first
   );
      logic [DIV_W-1:0]     a;
      logic [DIVISOR_W:0]   r;
      logic [DIVISOR_W-1:0] rr;
      a  = acc;
      rr = rem;
      for (int k = 0; k < DIV_STEP; k++) begin
         if (first + k < DIV_W) begin
            r = {rr, a[DIV_W-1]};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               a = {a[DIV_W-2:0], 1'b1};
            end else begin
               a = {a[DIV_W-2:0], 1'b0};
            end
            rr = r[DIVISOR_W-1:0];
         end
      end
      return {rr, a};
   endfunction

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            {rem_in[s], acc_in[s]} = div_stage(dividend, '0, divisor, 0);
         end else begin
            {rem_in[s], acc_in[s]} = div_stage(acc_ff[s-1], rem_ff[s-1], divisor,
                                               s * DIV_STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            acc_ff[s] <= acc_in[s];
            rem_ff[s] <= rem_in[s];
         end
      end
   end

   assign quotient = acc_ff[DIV_STAGES-1];

endmodule

[rtl/fpp_octave.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_octave: one octave of 2D gradient noise
// Corner hash, gradient sine/cosine, dot products and smoothstep blend.
// ----------------------------------------------------------------------------
module fpp_octave (
   input  logic                                clock,
   input  logic                                en,
   input  logic [fpp_pkg::DIV_W-1:0]           pos_x,
   input  logic [fpp_pkg::DIV_W-1:0]           pos_y,
   input  logic [31:0]                         hash_mul,
   output logic signed [fpp_pkg::NOISE_W-1:0]  noise
);
   import fpp_pkg::*;

   typedef struct packed {
      logic [15:0] base;
      logic [15:0] diff;
      logic [26:0] frac;
      logic        neg;
   } trig_type;

   typedef struct packed {
      logic [15:0] fx;
      logic [15:0] fy;
      logic [16:0] sx;
      logic [16:0] sy;
   } side_type;

   // stage 1
   logic [31:0] ax_ff [2], ax_in [2];
   logic [31:0] y_ff [2], y_in [2];
   logic [15:0] fx1_ff, fx1_in, fy1_ff, fy1_in;
   logic [31:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [31:0] x0_w;
   // stage 2
   logic [31:0] a2_ff [4], a2_in [4];
   logic [31:0] b2_ff [4], b2_in [4];
   side_type    side2_ff, side2_in;
   // stage 3
   logic [31:0] ph3_ff [4], ph3_in [4];
   side_type    side3_ff, side3_in;
   // stage 4
   trig_type    trig_w [8];
   logic [15:0] base4_ff [8], base4_in [8];
   logic [42:0] prod4_ff [8], prod4_in [8];
   logic        neg4_ff [8], neg4_in [8];
   side_type    side4_ff, side4_in;
   // stage 5
   logic [15:0]        val_w [8];
   logic signed [16:0] trig5_ff [8], trig5_in [8];
   side_type           side5_ff, side5_in;
   // stage 6
   logic signed [16:0]         dx_w [4], dy_w [4];
   logic signed [NOISE_W-1:0]  dot6_ff [4], dot6_in [4];
   side_type                   side6_ff, side6_in;
   // stage 7
   logic signed [NOISE_W-1:0]  top7_ff, top7_in, bot7_ff, bot7_in;
   logic [16:0]                sy7_ff, sy7_in;
   // stage 8
   logic signed [NOISE_W-1:0]  noise_ff, noise_in;

   function automatic logic [31:0] rotl16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic logic [16:0] smooth(input logic [31:0] sq, input logic [15:0] f);
      logic [17:0] m;
      logic [49:0] p;
      m = 18'd196608 - {1'b0, f, 1'b0};
      p = sq * m;
      return p[48:32];
   endfunction

   // fold the phase onto a quarter turn and pick the table segment
   function automatic trig_type trig_prep(input logic [31:0] p);
      logic [1:0]  q;
      logic [30:0] arg;
      trig_type    t;
      q = p[31:30];
      if (q == 2'd0 || q == 2'd2) begin
         arg = {1'b0, p[29:0]};
      end else begin
         arg = 31'h40000000 - {1'b0, p[29:0]};
      end
      t.neg = (q == 2'd1) || (q == 2'd2);
      if (arg[30]) begin
         t.base = '0;
         t.diff = '0;
         t.frac = '0;
      end else begin
         t.base = COS_TAB[arg[29:27]];
         t.diff = COS_STEP[arg[29:27]];
         t.frac = arg[26:0];
      end
      return t;
   endfunction

   function automatic logic signed [NOISE_W-1:0] dot(
      input logic signed [16:0] dx,
      input logic signed [16:0] dy,
      input logic signed [16:0] sn,
      input logic signed [16:0] cs
   );
      logic signed [NOISE_W:0] acc;
      acc = dx * sn + dy * cs;
      return acc[NOISE_W-1:0];
   endfunction

   // a0 + floor((a1 - a0) * s / 2^16)
   function automatic logic signed [NOISE_W-1:0] blend(
      input logic signed [NOISE_W-1:0] a0,
      input logic signed [NOISE_W-1:0] a1,
      input logic [16:0]               s
   );
      logic signed [NOISE_W:0]    d;
      logic signed [NOISE_W+18:0] p;
      logic signed [NOISE_W+18:0] r;
      d = $signed({a1[NOISE_W-1], a1}) - $signed({a0[NOISE_W-1], a0});
      p = d * $signed({1'b0, s});
      r = p >>> 16;
      return a0 + r[NOISE_W-1:0];
   endfunction

   always_comb begin
      // stage 1: corner coordinates, first hash multiply, fraction squares
      x0_w     = 32'(pos_x >> FRAC_BITS);
      ax_in[0] = x0_w * HASH_M1;
      ax_in[1] = (x0_w + 32'd1) * HASH_M1;
      y_in[0]  = 32'(pos_y >> FRAC_BITS);
      y_in[1]  = 32'(pos_y >> FRAC_BITS) + 32'd1;
      fx1_in   = pos_x[FRAC_BITS-1:0];
      fy1_in   = pos_y[FRAC_BITS-1:0];
      sqx_in   = fx1_in * fx1_in;
      sqy_in   = fy1_in * fy1_in;

      // stage 2: seeded multiply per corner, smoothstep weights
      for (int c = 0; c < 4; c++) begin
         a2_in[c] = ax_ff[c & 1];
         b2_in[c] = (y_ff[c >> 1] ^ rotl16(ax_ff[c & 1])) * hash_mul;
      end
      side2_in.fx = fx1_ff;
      side2_in.fy = fy1_ff;
      side2_in.sx = smooth(sqx_ff, fx1_ff);
      side2_in.sy = smooth(sqy_ff, fy1_ff);

      // stage 3: final hash multiply gives the gradient phase
      for (int c = 0; c < 4; c++) begin
         ph3_in[c] = (a2_ff[c] ^ rotl16(b2_ff[c])) * HASH_M3;
      end
      side3_in = side2_ff;

      // stage 4: table lookup and interpolation product, sine then cosine
      for (int e = 0; e < 8; e++) begin
         if (e[0]) begin
            trig_w[e] = trig_prep(ph3_ff[e >> 1]);
         end else begin
            trig_w[e] = trig_prep(ph3_ff[e >> 1] - 32'h40000000);
         end
         base4_in[e] = trig_w[e].base;
         neg4_in[e]  = trig_w[e].neg;
         prod4_in[e] = trig_w[e].diff * trig_w[e].frac;
      end
      side4_in = side3_ff;

      // stage 5: finish the interpolation and apply the quadrant sign
      for (int e = 0; e < 8; e++) begin
         val_w[e] = base4_ff[e] - prod4_ff[e][42:27];
         if (neg4_ff[e]) begin
            trig5_in[e] = -$signed({1'b0, val_w[e]});
         end else begin
            trig5_in[e] = $signed({1'b0, val_w[e]});
         end
      end
      side5_in = side4_ff;

      // stage 6: corner dot products
      for (int c = 0; c < 4; c++) begin
         dx_w[c]    = $signed({c[0], side5_ff.fx});
         dy_w[c]    = $signed({c[1], side5_ff.fy});
         dot6_in[c] = dot(dx_w[c], dy_w[c], trig5_ff[2*c], trig5_ff[2*c+1]);
      end
      side6_in = side5_ff;

      // stage 7: blend along x
      top7_in = blend(dot6_ff[0], dot6_ff[1], side6_ff.sx);
      bot7_in = blend(dot6_ff[2], dot6_ff[3], side6_ff.sx);
      sy7_in  = side6_ff.sy;

      // stage 8: blend along y
      noise_in = blend(top7_ff, bot7_ff, sy7_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= ax_in;
         y_ff     <= y_in;
         fx1_ff   <= fx1_in;
         fy1_ff   <= fy1_in;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         side2_ff <= side2_in;
         ph3_ff   <= ph3_in;
         side3_ff <= side3_in;
         base4_ff <= base4_in;
         prod4_ff <= prod4_in;
         neg4_ff  <= neg4_in;
         side4_ff <= side4_in;
         trig5_ff <= trig5_in;
         side5_ff <= side5_in;
         dot6_ff  <= dot6_in;
         side6_ff <= side6_in;
         top7_ff  <= top7_in;
         bot7_ff  <= bot7_in;
         sy7_ff   <= sy7_in;
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule

[rtl/fractal_perlin_pixel_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_perlin_pixel_generator: multi-octave Perlin noise pixel source
// Turns a pixel coordinate pair into a gray level and a packed pixel word.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer per pixel, carrying the outer and inner coordinate.
//   rsp_*  : one transfer per request, in request order, with both coordinates
//            echoed next to the gray level and the packed pixel word.
//   csr_*  : register writes (index 0 seed, index 1 grid size); ready whenever
//            reset is low. Write only while no pixel is in flight.
// Throughput: one pixel per cycle while the output does not stall. Every
//   octave has a lane of its own, both coordinate dividers retire DIV_STEP
//   quotient bits per stage, and the divide by ten is a reciprocal multiply
//   split over two stages.
// Path: from request transfer to response valid, coordinate divide, octave
//   lane, octave sum, contrast, divide by ten, gray and pixel packing.
// Reset: clears every stage valid bit, sets seed to 0 and grid size to 400;
//   req_ready and csr_ready stay low while reset is high.
// Stall: while a response waits with rsp_ready low the whole pipeline holds
//   and req_ready drops; nothing is lost or repeated. With the output stage
//   empty, or rsp_ready high, a new request is taken every cycle.
// ----------------------------------------------------------------------------
module fractal_perlin_pixel_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fpp_pkg::COORD_BITS-1:0]       req_outer_coord,
   input  logic [fpp_pkg::COORD_BITS-1:0]       req_inner_coord,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fpp_pkg::COORD_BITS-1:0]       rsp_out_outer,
   output logic [fpp_pkg::COORD_BITS-1:0]       rsp_out_inner,
   output logic [fpp_pkg::GRAY_W-1:0]           rsp_gray_level,
   output logic [fpp_pkg::PIXEL_W-1:0]          rsp_pixel_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fpp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                          csr_data
);
   import fpp_pkg::*;

   localparam int X_W = SUM_W + 4;
   // floor(x / 10) clipped to +-2^31 equals floor of x clipped to these bounds
   localparam logic signed [X_W-1:0] CLIP_HI = X_W'(64'sd21474836489);
   localparam logic signed [X_W-1:0] CLIP_LO = X_W'(-64'sd21474836480);
   localparam logic signed [X_W-1:0] BIAS    = X_W'(64'sd21474836480);
   localparam int POS_SHIFT = FRAC_BITS + OCTAVES - 1;
   // ceil(2^38 / 5): floor(n * M / 2^38) = floor(n / 5) for any n below 2^35
   localparam logic [35:0] RECIP_M = 36'd54975581389;

   // configuration
   logic [31:0]          hmul_ff;
   logic [DIVISOR_W-1:0] grid_ff;

   // pipeline control
   logic                  en;
   logic                  vld_ff [PIPE_DEPTH];
   logic [COORD_BITS-1:0] outer_ff [PIPE_DEPTH];
   logic [COORD_BITS-1:0] inner_ff [PIPE_DEPTH];

   // datapath
   logic [DIV_W-1:0]          qx, qy;
   logic signed [NOISE_W-1:0] lane_noise [OCTAVES];
   logic signed [SUM_W-1:0]   part_ff [GROUPS], part_in [GROUPS];
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [X_W-1:0]     x_w, xc_w;
   logic [DIV_W-1:0]          u_ff, u_in;
   logic [34:0]               recip_n_w;
   logic [35:0]               rp_ff [4], rp_in [4];
   logic [70:0]               recip_w;
   logic [32:0]               q10_ff, q10_in;
   logic [33:0]               t_w;
   logic [41:0]               g255_w;
   logic [GRAY_W-1:0]         gray_ff, gray_in;
   logic [4:0]                g16_w;
   logic [PIXEL_W-1:0]        pixel_ff, pixel_in;

   // the whole pipeline advances unless a finished response is held back
   assign en        = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = en && !reset;
   assign csr_ready = !reset;

   // register writes: keep the seeded multiplier and a nonzero grid size
   always_ff @(posedge clock) begin
      if (reset) begin
         hmul_ff <= HASH_M2;
         grid_ff <= GRID_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEED: hmul_ff <= HASH_M2 + csr_data;
            CSR_GRID: begin
               if (csr_data[DIVISOR_W-1:0] == '0) begin
                  grid_ff <= DIVISOR_W'(1);
               end else begin
                  grid_ff <= csr_data[DIVISOR_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // valid bits and coordinate echo travel alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_DEPTH; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         outer_ff[0] <= req_outer_coord;
         inner_ff[0] <= req_inner_coord;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            outer_ff[s] <= outer_ff[s-1];
            inner_ff[s] <= inner_ff[s-1];
         end
      end
   end

   // position at the finest octave; coarser octaves are right shifts of it
   fpp_div u_div_x (
      .clock    (clock),
      .en       (en),
      .dividend (DIV_W'(req_outer_coord) << POS_SHIFT),
      .divisor  (grid_ff),
      .quotient (qx)
   );

   fpp_div u_div_y (
      .clock    (clock),
      .en       (en),
      .dividend (DIV_W'(req_inner_coord) << POS_SHIFT),
      .divisor  (grid_ff),
      .quotient (qy)
   );

   for (genvar i = 0; i < OCTAVES; i++) begin : g_lane
      fpp_octave u_octave (
         .clock    (clock),
         .en       (en),
         .pos_x    (qx >> (OCTAVES - 1 - i)),
         .pos_y    (qy >> (OCTAVES - 1 - i)),
         .hash_mul (hmul_ff),
         .noise    (lane_noise[i])
      );
   end

   always_comb begin
      // weight each octave by 2^-i (floor) and add in groups of four
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < 4; k++) begin
            if (4*g + k < OCTAVES) begin
               part_in[g] = part_in[g] + (SUM_W'(lane_noise[4*g+k]) >>> (4*g + k));
            end
         end
      end
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + part_ff[g];
      end

      // contrast: times nine, clip, bias positive for the divide by ten
      x_w = (X_W'(sum_ff) <<< 3) + X_W'(sum_ff);
      if (x_w > CLIP_HI) begin
         xc_w = CLIP_HI;
      end else if (x_w < CLIP_LO) begin
         xc_w = CLIP_LO;
      end else begin
         xc_w = x_w;
      end
      u_in = DIV_W'(xc_w + BIAS);

      // divide by ten: halve, then multiply by the reciprocal of five in
      // 17- and 18-bit pieces; sum the pieces in the next stage
      recip_n_w = u_ff[35:1];
      rp_in[0]  = recip_n_w[34:17] * RECIP_M[35:18];
      rp_in[1]  = recip_n_w[34:17] * RECIP_M[17:0];
      rp_in[2]  = recip_n_w[16:0] * RECIP_M[35:18];
      rp_in[3]  = recip_n_w[16:0] * RECIP_M[17:0];
      recip_w   = {rp_ff[0], 35'b0} + {18'b0, rp_ff[1], 17'b0}
                  + {17'b0, rp_ff[2], 18'b0} + {35'b0, rp_ff[3]};
      q10_in    = recip_w[70:38];

      // quotient is v + 2^31; gray = floor((v + 2^32) * 255 / 2^32)
      t_w      = {1'b0, q10_ff} + 34'h080000000;
      g255_w   = {t_w, 8'b0} - {8'b0, t_w};
      gray_in  = g255_w[40:32];
      g16_w    = gray_in[8:4];
      pixel_in = {g16_w, 12'b0} + {4'b0, g16_w, 8'b0} + {8'b0, g16_w, 4'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_ff  <= part_in;
         sum_ff   <= sum_in;
         u_ff     <= u_in;
         rp_ff    <= rp_in;
         q10_ff   <= q10_in;
         gray_ff  <= gray_in;
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid      = vld_ff[PIPE_DEPTH-1];
   assign rsp_out_outer  = outer_ff[PIPE_DEPTH-1];
   assign rsp_out_inner  = inner_ff[PIPE_DEPTH-1];
   assign rsp_gray_level = gray_ff;
   assign rsp_pixel_word = pixel_ff;

endmodule

[rtl/fpp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_checker: port-level checks for the pixel generator
// Output hold under stall, ready behavior, gray range and pixel packing.
// ----------------------------------------------------------------------------
module fpp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [fpp_pkg::COORD_BITS-1:0]       rsp_out_outer,
   input logic [fpp_pkg::GRAY_W-1:0]           rsp_gray_level,
   input logic [fpp_pkg::PIXEL_W-1:0]          rsp_pixel_word
);
   import fpp_pkg::*;

   logic [4:0]         g16;
   logic [PIXEL_W-1:0] pixel_exp;

   assign g16       = rsp_gray_level[8:4];
   assign pixel_exp = {g16, 12'b0} + {4'b0, g16, 8'b0} + {8'b0, g16, 4'b0};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gray_level)
                                  && $stable(rsp_out_outer))
      else $error("response dropped or changed while stalled");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   a_gray_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gray_level >= 9'd127 && rsp_gray_level <= 9'd382)
      else $error("gray level out of range");

   a_pixel_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_word == pixel_exp)
      else $error("pixel word does not match gray level");

endmodule

bind fractal_perlin_pixel_generator fpp_checker u_fpp_checker (.*);

[tb/fractal_perlin_pixel_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_perlin_pixel_generator_tb: self-checking bench for the noise pixel block
// Drives coordinate pairs through the request channel, predicts each pixel
// with an independent fixed-point fBm Perlin model, and compares responses in
// order. Seed and grid size are swept across phases, with random idling.
// ----------------------------------------------------------------------------
module fractal_perlin_pixel_generator_tb;
   import fpp_pkg::*;

   localparam int MAX_CYCLES = 2000000;

   // expected pixel record
   typedef struct packed {
      logic [COORD_BITS-1:0] outer;
      logic [COORD_BITS-1:0] inner;
      logic [GRAY_W-1:0]     gray;
      logic [PIXEL_W-1:0]    word;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COORD_BITS-1:0] req_outer_coord = '0;
   logic [COORD_BITS-1:0] req_inner_coord = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COORD_BITS-1:0] rsp_out_outer;
   logic [COORD_BITS-1:0] rsp_out_inner;
   logic [GRAY_W-1:0]     rsp_gray_level;
   logic [PIXEL_W-1:0]    rsp_pixel_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [31:0]           csr_data = '0;

   // predictor copy of the register file
   logic [31:0] model_seed = 32'd0;
   logic [15:0] model_grid = 16'd400;

   pixel_type pending_pixels[$];
   int     err_count = 0;
   int     cycle_count = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;

   fractal_perlin_pixel_generator u_top (.*);

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint fl_shr(longint v, int s);
      return v >>> s;   // arithmetic shift floors toward minus infinity
   endfunction

   function automatic longint quarter_cos(logic [31:0] arg);
      int         idx;
      longint     f, d;
      longint     tab_hi, tab_lo;
      idx = arg >> 27;
      if (idx >= 8) return 0;
      tab_hi = (idx == 0) ? 32767 : (idx == 1) ? 32138 : (idx == 2) ? 30273 :
               (idx == 3) ? 27245 : (idx == 4) ? 23170 : (idx == 5) ? 18205 :
               (idx == 6) ? 12540 : 6393;
      tab_lo = (idx == 0) ? 32138 : (idx == 1) ? 30273 : (idx == 2) ? 27245 :
               (idx == 3) ? 23170 : (idx == 4) ? 18205 : (idx == 5) ? 12540 :
               (idx == 6) ? 6393 : 0;
      f = arg & 32'h07FF_FFFF;
      d = ((tab_hi - tab_lo) * f) >> 27;
      return tab_hi - d;
   endfunction

   function automatic longint gradient_cos(logic [31:0] p);
      logic [31:0] r;
      r = p & 32'h3FFF_FFFF;
      case (p[31:30])
         2'd0: return quarter_cos(r);
         2'd1: return -quarter_cos(32'h4000_0000 - r);
         2'd2: return -quarter_cos(r);
         default: return quarter_cos(32'h4000_0000 - r);
      endcase
   endfunction

   function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] a, b;
      a = cx * HASH_M1;
      b = cy ^ {a[15:0], a[31:16]};
      b = b * (HASH_M2 + model_seed);
      a = a ^ {b[15:0], b[31:16]};
      return a * HASH_M3;
   endfunction

   function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
                                           longint dx, longint dy);
      logic [31:0] ph;
      ph = lattice_hash(cx, cy);
      return dx * gradient_cos(ph - 32'h4000_0000) + dy * gradient_cos(ph);
   endfunction

   function automatic longint fade(longint f);
      return (f * f * (196608 - 2 * f)) >>> 32;
   endfunction

   function automatic longint lerp_q16(longint a0, longint a1, longint s);
      return a0 + fl_shr((a1 - a0) * s, 16);
   endfunction

   function automatic longint perlin_sample(longint px, longint py);
      logic [31:0] x0, y0;
      longint      fx, fy, sx, sy, top, bot;
      x0 = 32'(px >> 16);
      y0 = 32'(py >> 16);
      fx = px & 16'hFFFF;
      fy = py & 16'hFFFF;
      sx = fade(fx);
      sy = fade(fy);
      top = lerp_q16(gradient_dot(x0, y0, fx, fy),
                     gradient_dot(x0 + 1, y0, fx - 65536, fy), sx);
      bot = lerp_q16(gradient_dot(x0, y0 + 1, fx, fy - 65536),
                     gradient_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
      return lerp_q16(top, bot, sy);
   endfunction

   function automatic pixel_type shade_pixel(logic [COORD_BITS-1:0] ox,
                                             logic [COORD_BITS-1:0] iy);
      pixel_type px;
      longint g, acc, v, gray, g16;
      g = (model_grid == 0) ? 1 : model_grid;
      acc = 0;
      for (int i = 0; i < OCTAVES; i++)
         acc += fl_shr(perlin_sample((longint'(ox) << (16 + i)) / g,
                                     (longint'(iy) << (16 + i)) / g), i);
      v = acc * 9;
      v = (v >= 0) ? v / 10 : -((-v + 9) / 10);
      if (v > 64'sd2147483648) v = 64'sd2147483648;
      else if (v < -64'sd2147483648) v = -64'sd2147483648;
      gray = ((v + 64'sd4294967296) * 255) >> 32;
      g16 = gray / 16;
      px.outer = ox;
      px.inner = iy;
      px.gray = gray[GRAY_W-1:0];
      px.word = PIXEL_W'((g16 << 12) + (g16 << 8) + (g16 << 4));
      return px;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected response outer=%0d inner=%0d", rsp_out_outer, rsp_out_inner);
            err_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_outer !== want.outer) begin
               $error("out_outer exp %0d got %0d", want.outer, rsp_out_outer);
               err_count++;
            end
            if (rsp_out_inner !== want.inner) begin
               $error("out_inner exp %0d got %0d", want.inner, rsp_out_inner);
               err_count++;
            end
            if (rsp_gray_level !== want.gray) begin
               $error("gray_level exp %0d got %0d", want.gray, rsp_gray_level);
               err_count++;
            end
            if (rsp_pixel_word !== want.word) begin
               $error("pixel_word exp %0d got %0d", want.word, rsp_pixel_word);
               err_count++;
            end
         end
      end
   end

   // receiver stall: redraw at each falling edge
   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- tasks
   // valid stays up after a transfer; idle cycles and drain_pipe drop it
   task automatic send_pixel(logic [COORD_BITS-1:0] ox, logic [COORD_BITS-1:0] iy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_outer_coord <= ox;
      req_inner_coord <= iy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(shade_pixel(ox, iy));
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // mirror the write; out-of-range indexes are dropped
      if (idx == CSR_SEED) model_seed = value;
      else if (idx == CSR_GRID) model_grid = value[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_directed();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(12'd400, 12'd400);
      send_pixel(12'd399, 12'd401);
      send_pixel(12'd1, 12'd2048);
      drain_pipe();
      // zero grid acts as one cell per pixel; also try a bogus index
      write_csr(CSR_GRID, 32'd0);
      write_csr(CSR_IDX_W'(7), 32'hDEAD_BEEF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'h001);
      send_pixel(12'h123, 12'hFED);
      drain_pipe();
      write_csr(CSR_GRID, 32'hFFFF_FFFF);   // upper bits drop, grid 65535
      write_csr(CSR_SEED, 32'hFFFF_FFFF);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd0, 12'h800);
      drain_pipe();
      write_csr(CSR_GRID, 32'd1);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'h7FF, 12'h800);
      drain_pipe();
   endtask

   task automatic test_random_phase(logic [31:0] seed_val, logic [15:0] grid_val, int count);
      write_csr(CSR_SEED, seed_val);
      write_csr(CSR_GRID, {16'd0, grid_val});
      for (int n = 0; n < count; n++)
         send_pixel(COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)));
      drain_pipe();
   endtask

   task automatic test_random();
      // first stretch: sender rarely idle, receiver often stalled
      send_idle_pct = 8;  recv_idle_pct = 51;
      test_random_phase(32'd0, 16'd400, 220);
      test_random_phase($urandom, 16'd1, 200);
      // swap idling
      send_idle_pct = 51; recv_idle_pct = 8;
      test_random_phase($urandom, 16'hFFFF, 200);
      test_random_phase($urandom, 16'($urandom_range(2, 64)), 220);
      // back to back
      send_idle_pct = 0;  recv_idle_pct = 0;
      test_random_phase(32'hFFFF_FFFF, 16'($urandom_range(65, 2000)), 220);
      test_random_phase($urandom, 16'($urandom_range(1, 65535)), 220);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      drain_pipe();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
rtl/fpp_pkg.sv
rtl/fpp_div.sv
rtl/fpp_octave.sv
rtl/fractal_perlin_pixel_generator.sv
rtl/fpp_checker.sv
tb/fractal_perlin_pixel_generator_tb.sv
